/* hw/rtl/ast_pkg.sv */
// Shared types and constants for the acceleration split timer.
`default_nettype none

package ast_pkg;

    localparam int FUNC_W    = 2;
    localparam int SPEED_W   = 16;
    localparam int IDX_W     = 5;
    localparam int PHASE_W   = 3;
    localparam int COUNT_W   = 6;
    localparam int MS_W      = 16;
    localparam int ENTRY_W   = 3 * MS_W;
    localparam int CFG_IDX_W = 3;
    localparam int CLIP_W    = 26;   // us values below the saturation point fit here

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_THIRD  = 3'd3,
        PH_SAVED  = 3'd4
    } t_phase;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM     = 3'd5;

    // configuration reset values, 1/16 kph
    localparam logic [SPEED_W-1:0] RST_BAND_LOW  = 16'd112;
    localparam logic [SPEED_W-1:0] RST_BAND_HIGH = 16'd160;
    localparam logic [SPEED_W-1:0] RST_MARK1     = 16'd1280;
    localparam logic [SPEED_W-1:0] RST_MARK2     = 16'd1600;
    localparam logic [SPEED_W-1:0] RST_MARK3     = 16'd1920;
    localparam logic [SPEED_W-1:0] RST_REARM     = 16'd160;

    // us -> ms: divide by 1000 as multiply by ceil(2^36/1000), shift by 36.
    // Exact for every input below 2^26.
    localparam logic [CLIP_W-1:0] MS_SAT_US = 26'd65536000;
    localparam logic [26:0]       MS_RECIP  = 27'd68719477;
    localparam int                MS_SHIFT  = 36;
    localparam logic [MS_W-1:0]   MS_MAX    = 16'hFFFF;

    function automatic logic [MS_W-1:0] ms_from_us(input logic [CLIP_W-1:0] us);
        logic [CLIP_W+26:0] prod;
        prod = (CLIP_W+27)'(us) * (CLIP_W+27)'(MS_RECIP);
        return prod[MS_SHIFT +: MS_W];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/acceleration_split_timer_core.sv */
// Acceleration split timer: top level with run phase machine and split history.
`default_nettype none

// Acceleration split timer. Each input transaction is a speed sample, a history
// read or a history clear; each produces exactly one result transaction that
// shows the run phase, the latest split deltas in microseconds, the number of
// saved runs and, for a read, the history entry. Speeds are unsigned 1/16 kph.
// Marks are crossed at speed >= threshold; a run is saved in milliseconds
// (truncated, saturating at 65535) when speed falls below the third mark, until
// the history holds HISTORY_DEPTH runs. Rate: one transaction per clock cycle
// sustained while i_out_stall is low; an input register is followed by the
// result register. The phase machine and its time/delta registers are updated
// in the result stage, which is what lets samples follow back to back. History
// is a single-write, single-read memory read at accept time with a bypass for a
// save in the same cycle; clear zeroes the run state and the fill count but not
// the memory, so no clearing pass is needed. Configuration is taken every cycle
// (ready is always high) and must only be written while the block is idle.
module acceleration_split_timer_core #(
    parameter int HISTORY_DEPTH = 32,
    parameter int TIME_BITS     = 48
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [ast_pkg::FUNC_W-1:0]   i_func,
    input  wire  [TIME_BITS-1:0]         i_time_us,
    input  wire  [ast_pkg::SPEED_W-1:0]  i_speed,
    input  wire  [ast_pkg::IDX_W-1:0]    i_read_index,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_event_flag,
    output logic [ast_pkg::PHASE_W-1:0]  o_phase,
    output logic [TIME_BITS-1:0]         o_split_start_to_second_us,
    output logic [TIME_BITS-1:0]         o_split_first_to_second_us,
    output logic [TIME_BITS-1:0]         o_split_first_to_third_us,
    output logic [ast_pkg::COUNT_W-1:0]  o_sample_count,
    output logic                         o_read_valid,
    output logic [ast_pkg::MS_W-1:0]     o_read_start_to_first_ms,
    output logic [ast_pkg::MS_W-1:0]     o_read_first_to_second_ms,
    output logic [ast_pkg::MS_W-1:0]     o_read_first_to_third_ms,
    // configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [ast_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [ast_pkg::SPEED_W-1:0]  i_cfg_data
);

    import ast_pkg::*;

    // history address / fill count widths
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;
    localparam int KW = (CW > IDX_W) ? CW : IDX_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SPEED_W-1:0] r_band_low, r_band_high, r_mark1, r_mark2, r_mark3, r_rearm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low  <= RST_BAND_LOW;
            r_band_high <= RST_BAND_HIGH;
            r_mark1     <= RST_MARK1;
            r_mark2     <= RST_MARK2;
            r_mark3     <= RST_MARK3;
            r_rearm     <= RST_REARM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAND_LOW:  r_band_low  <= i_cfg_data;
                CFG_BAND_HIGH: r_band_high <= i_cfg_data;
                CFG_MARK1:     r_mark1     <= i_cfg_data;
                CFG_MARK2:     r_mark2     <= i_cfg_data;
                CFG_MARK3:     r_mark3     <= i_cfg_data;
                CFG_REARM:     r_rearm     <= i_cfg_data;
                default: ;     // unmapped index, dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load;
    logic s2_fire;
    logic in_accept;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s2_fire    = r_s1_valid && out_load;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Run state
    // ---------------------------------------------------------------
    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_start_t, n_start_t;
    logic [TIME_BITS-1:0] r_first_t, n_first_t;
    logic [TIME_BITS-1:0] r_second_t, n_second_t;
    logic [TIME_BITS-1:0] r_third_t, n_third_t;
    logic [TIME_BITS-1:0] r_d_s1, n_d_s1;   // start to first
    logic [TIME_BITS-1:0] r_d_s2, n_d_s2;   // start to second
    logic [TIME_BITS-1:0] r_d_12, n_d_12;   // first to second
    logic [TIME_BITS-1:0] r_d_13, n_d_13;   // first to third
    logic [CW-1:0]        r_saved, n_saved;

    // ---------------------------------------------------------------
    // Stage 1: input register plus history read
    // ---------------------------------------------------------------
    logic [FUNC_W-1:0]    r_s1_func;
    logic [TIME_BITS-1:0] r_s1_time;
    logic [SPEED_W-1:0]   r_s1_speed;
    logic [IDX_W-1:0]     r_s1_idx;
    logic [ENTRY_W-1:0]   r_s1_rd_data;
    logic                 r_s1_fwd;
    logic [ENTRY_W-1:0]   r_s1_fwd_data;

    logic [ENTRY_W-1:0]   r_hist_mem [HISTORY_DEPTH];

    logic [XW-1:0]        idx_x;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;

    assign idx_x   = XW'(i_read_index);
    assign rd_addr = idx_x[AW-1:0];
    assign wr_addr = r_saved[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func     <= i_func;
            r_s1_time     <= i_time_us;
            r_s1_speed    <= i_speed;
            r_s1_idx      <= i_read_index;
            r_s1_rd_data  <= r_hist_mem[rd_addr];
            // a save leaving stage 2 this cycle is not in the memory yet
            r_s1_fwd      <= wr_en && (wr_addr == rd_addr);
            r_s1_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist_mem[wr_addr] <= wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: phase machine
    // ---------------------------------------------------------------
    logic [MS_W-1:0] ms_s1, ms_12, ms_13;
    logic            ev;
    logic            rd_ok;
    logic [ENTRY_W-1:0] rd_entry;

    // Saved deltas: the registered deltas are stored as they are; they equal deltas
    // recomputed from the mark times, since those cannot move between phases 1 and 4.
    always_comb begin
        ms_s1 = (r_d_s1 >= TIME_BITS'(MS_SAT_US)) ? MS_MAX : ms_from_us(r_d_s1[CLIP_W-1:0]);
        ms_12 = (r_d_12 >= TIME_BITS'(MS_SAT_US)) ? MS_MAX : ms_from_us(r_d_12[CLIP_W-1:0]);
        ms_13 = (r_d_13 >= TIME_BITS'(MS_SAT_US)) ? MS_MAX : ms_from_us(r_d_13[CLIP_W-1:0]);
    end

    assign wr_data = {ms_13, ms_12, ms_s1};

    always_comb begin
        n_phase    = r_phase;
        n_start_t  = r_start_t;
        n_first_t  = r_first_t;
        n_second_t = r_second_t;
        n_third_t  = r_third_t;
        n_d_s1     = r_d_s1;
        n_d_s2     = r_d_s2;
        n_d_12     = r_d_12;
        n_d_13     = r_d_13;
        n_saved    = r_saved;
        ev         = 1'b0;
        wr_en      = 1'b0;
        rd_ok      = 1'b0;

        unique case (r_s1_func)
            FUNC_SAMPLE: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (r_s1_speed >= r_band_low && r_s1_speed < r_band_high) begin
                            n_start_t = r_s1_time;
                        end
                        if (r_s1_speed >= r_mark1) begin
                            n_first_t = r_s1_time;
                            n_d_s1    = r_s1_time - n_start_t;
                            n_phase   = PH_FIRST;
                        end
                    end
                    PH_FIRST: begin
                        if (r_s1_speed >= r_mark2) begin
                            n_second_t = r_s1_time;
                            n_d_12     = r_s1_time - r_first_t;
                            n_phase    = PH_SECOND;
                            ev         = 1'b1;
                        end
                    end
                    PH_SECOND: begin
                        if (r_s1_speed >= r_mark3) begin
                            n_third_t = r_s1_time;
                            n_d_13    = r_s1_time - r_first_t;
                            n_d_s2    = r_second_t - r_start_t;
                            n_phase   = PH_THIRD;
                            ev        = 1'b1;
                        end
                    end
                    PH_THIRD: begin
                        if (r_s1_speed < r_mark3) begin
                            n_phase = PH_SAVED;
                            ev      = 1'b1;
                            if (r_saved < CW'(HISTORY_DEPTH)) begin
                                wr_en   = s2_fire;
                                n_saved = r_saved + CW'(1);
                            end
                        end
                    end
                    default: begin
                        // saved: wait for the car to slow down
                        if (r_s1_speed < r_rearm) begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
            FUNC_READ: begin
                rd_ok = KW'(r_s1_idx) < KW'(r_saved);
            end
            FUNC_CLEAR: begin
                n_phase    = PH_IDLE;
                n_start_t  = '0;
                n_first_t  = '0;
                n_second_t = '0;
                n_third_t  = '0;
                n_d_s1     = '0;
                n_d_s2     = '0;
                n_d_12     = '0;
                n_d_13     = '0;
                n_saved    = '0;
            end
            default: ;  // unused code: status only
        endcase
    end

    assign rd_entry = r_s1_fwd ? r_s1_fwd_data : r_s1_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_start_t  <= '0;
            r_first_t  <= '0;
            r_second_t <= '0;
            r_third_t  <= '0;
            r_d_s1     <= '0;
            r_d_s2     <= '0;
            r_d_12     <= '0;
            r_d_13     <= '0;
            r_saved    <= '0;
        end else if (s2_fire) begin
            r_phase    <= n_phase;
            r_start_t  <= n_start_t;
            r_first_t  <= n_first_t;
            r_second_t <= n_second_t;
            r_third_t  <= n_third_t;
            r_d_s1     <= n_d_s1;
            r_d_s2     <= n_d_s2;
            r_d_12     <= n_d_12;
            r_d_13     <= n_d_13;
            r_saved    <= n_saved;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            o_event_flag               <= ev;
            o_phase                    <= n_phase;
            o_split_start_to_second_us <= n_d_s2;
            o_split_first_to_second_us <= n_d_12;
            o_split_first_to_third_us  <= n_d_13;
            o_sample_count             <= COUNT_W'(n_saved);
            o_read_valid               <= rd_ok;
            o_read_start_to_first_ms   <= rd_ok ? rd_entry[0 +: MS_W]      : '0;
            o_read_first_to_second_ms  <= rd_ok ? rd_entry[MS_W +: MS_W]   : '0;
            o_read_first_to_third_ms   <= rd_ok ? rd_entry[2*MS_W +: MS_W] : '0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for acceleration_split_timer_core: run-timer tracker class plus stimulus.
`timescale 1ns / 100ps

module tb;
    import ast_pkg::*;

    localparam int          TIME_W       = 48;
    localparam int          RUN_SLOTS    = 32;
    localparam int          DUT_LATENCY  = 2;
    localparam int          HOLD_CYCLES  = 120;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          US_PER_MS    = 1000;
    localparam logic [TIME_W-1:0]  TIME_TOP    = '1;
    // func code the block leaves unassigned; it must still answer with a status
    localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;

    // one speed threshold per configuration register, indexed by register
    typedef logic [CFG_MARK3+1:CFG_BAND_LOW][SPEED_W-1:0] t_reg_set;

    typedef struct {
        logic                 ev;
        logic [PHASE_W-1:0]   ph;
        logic [TIME_W-1:0]    s2;
        logic [TIME_W-1:0]    d12;
        logic [TIME_W-1:0]    d13;
        logic [COUNT_W-1:0]   runs;
        logic                 rd_ok;
        logic [MS_W-1:0]      rd_s1;
        logic [MS_W-1:0]      rd_12;
        logic [MS_W-1:0]      rd_13;
    } t_split_result;

    // Tracks the run timer from accepted transactions and holds the results still owed.
    class t_split_tracker;
        t_reg_set            thr;
        t_phase              run_ph;
        logic [TIME_W-1:0]   t_start, t_first, t_second, t_third;
        logic [TIME_W-1:0]   d_s1, d_s2, d_12, d_13;
        logic [ENTRY_W-1:0]  history [RUN_SLOTS];
        int unsigned         runs_saved;
        t_split_result       owed_results [$];
        int unsigned         failures;

        function new();
            thr[CFG_BAND_LOW]  = RST_BAND_LOW;
            thr[CFG_BAND_HIGH] = RST_BAND_HIGH;
            thr[CFG_MARK1]     = RST_MARK1;
            thr[CFG_MARK2]     = RST_MARK2;
            thr[CFG_MARK3]     = RST_MARK3;
            thr[CFG_REARM]     = RST_REARM;
            failures = 0;
            clear_run();
        endfunction

        function void clear_run();
            run_ph = PH_IDLE;
            {t_start, t_first, t_second, t_third} = '0;
            {d_s1, d_s2, d_12, d_13} = '0;
            foreach (history[i]) history[i] = '0;
            runs_saved = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
            thr[idx] = data;
        endfunction

        function logic [MS_W-1:0] to_ms(logic [TIME_W-1:0] us);
            logic [TIME_W-1:0] whole_ms;
            whole_ms = us / TIME_W'(US_PER_MS);
            return (whole_ms > TIME_W'(MS_MAX)) ? MS_MAX : whole_ms[MS_W-1:0];
        endfunction

        // phase machine on one speed sample; returns the event
        function bit take_speed(logic [TIME_W-1:0] t, logic [SPEED_W-1:0] v);
            case (run_ph)
                PH_IDLE: begin
                    if (v >= thr[CFG_BAND_LOW] && v < thr[CFG_BAND_HIGH])
                        t_start = t;
                    if (v >= thr[CFG_MARK1]) begin
                        t_first = t;
                        d_s1    = t - t_start;
                        run_ph  = PH_FIRST;
                    end
                end
                PH_FIRST: if (v >= thr[CFG_MARK2]) begin
                    t_second = t;
                    d_12     = t - t_first;
                    run_ph   = PH_SECOND;
                    return 1'b1;
                end
                PH_SECOND: if (v >= thr[CFG_MARK3]) begin
                    t_third = t;
                    d_13    = t - t_first;
                    d_s2    = t_second - t_start;
                    run_ph  = PH_THIRD;
                    return 1'b1;
                end
                PH_THIRD: if (v < thr[CFG_MARK3]) begin
                    run_ph = PH_SAVED;
                    d_12   = t_second - t_first;
                    d_13   = t_third - t_first;
                    // full history: run dropped, count frozen, event still raised
                    if (runs_saved < RUN_SLOTS) begin
                        history[runs_saved] = {to_ms(d_13), to_ms(d_12), to_ms(d_s1)};
                        runs_saved++;
                    end
                    return 1'b1;
                end
                default: if (v < thr[CFG_REARM]) run_ph = PH_IDLE;
            endcase
            return 1'b0;
        endfunction

        function void absorb_item(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] t,
                                  logic [SPEED_W-1:0] v, logic [IDX_W-1:0] idx);
            t_split_result r;
            r = '{default: '0};
            case (f)
                FUNC_SAMPLE: r.ev = take_speed(t, v);
                FUNC_READ: if (idx < runs_saved) begin
                    r.rd_ok = 1'b1;
                    {r.rd_13, r.rd_12, r.rd_s1} = history[idx];
                end
                FUNC_CLEAR: clear_run();
                default: ;
            endcase
            r.ph   = run_ph;
            r.s2   = d_s2;
            r.d12  = d_12;
            r.d13  = d_13;
            r.runs = COUNT_W'(runs_saved);
            owed_results.push_back(r);
        endfunction

        function void match(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_split_result got);
            t_split_result want;
            if (owed_results.size() == 0) begin
                $error("result transaction with no input transaction outstanding");
                failures++;
                return;
            end
            want = owed_results.pop_front();
            match("event_flag", want.ev, got.ev);
            match("phase", want.ph, got.ph);
            match("split_start_to_second_us", want.s2, got.s2);
            match("split_first_to_second_us", want.d12, got.d12);
            match("split_first_to_third_us", want.d13, got.d13);
            match("sample_count", want.runs, got.runs);
            match("read_valid", want.rd_ok, got.rd_ok);
            match("read_start_to_first_ms", want.rd_s1, got.rd_s1);
            match("read_first_to_second_ms", want.rd_12, got.rd_12);
            match("read_first_to_third_ms", want.rd_13, got.rd_13);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid, in_stall;
    logic [FUNC_W-1:0]     func;
    logic [TIME_W-1:0]     time_us;
    logic [SPEED_W-1:0]    speed;
    logic [IDX_W-1:0]      read_index;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  event_flag;
    logic [PHASE_W-1:0]    phase;
    logic [TIME_W-1:0]     split_s2, split_12, split_13;
    logic [COUNT_W-1:0]    run_count;
    logic                  read_ok;
    logic [MS_W-1:0]       read_s1, read_12, read_13;
    logic                  cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SPEED_W-1:0]    cfg_data;

    t_split_tracker tracker = new();
    t_split_result  seen;
    logic [TIME_W-1:0] clock_us;       // sample timestamp, advanced by next_stamp
    int unsigned  items_sent = 0;
    int unsigned  cycles = 0;
    bit           tx_calm, rx_calm;    // suppress random idling on either side
    int unsigned  hold_asks = 0;       // bumped by stimulus to request a long receiver hold
    int unsigned  holds_done = 0;
    int unsigned  hold_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    acceleration_split_timer_core #(
        .HISTORY_DEPTH(RUN_SLOTS),
        .TIME_BITS(TIME_W)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_func(func),
        .i_time_us(time_us),
        .i_speed(speed),
        .i_read_index(read_index),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_event_flag(event_flag),
        .o_phase(phase),
        .o_split_start_to_second_us(split_s2),
        .o_split_first_to_second_us(split_12),
        .o_split_first_to_third_us(split_13),
        .o_sample_count(run_count),
        .o_read_valid(read_ok),
        .o_read_start_to_first_ms(read_s1),
        .o_read_first_to_second_ms(read_12),
        .o_read_first_to_third_ms(read_13),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    // Input side: every accepted transaction goes to the tracker.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            tracker.absorb_item(func, time_us, speed, read_index);
    end

    // Result side: compare every accepted result transaction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen.ev    = event_flag;
            seen.ph    = phase;
            seen.s2    = split_s2;
            seen.d12   = split_12;
            seen.d13   = split_13;
            seen.runs  = run_count;
            seen.rd_ok = read_ok;
            seen.rd_s1 = read_s1;
            seen.rd_12 = read_12;
            seen.rd_13 = read_13;
            tracker.check_result(seen);
        end
    end

    // Receiver stall: random, or a long hold counted here when requested,
    // so the pipeline backs up into the input channel.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (holds_done != hold_asks) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !rx_calm && ($urandom_range(99) < 25);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** acceleration_split_timer_core: FAILED **");
            $finish;
        end
    end

    // Offer one transaction and hold it until the block takes it.
    task automatic offer(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] t,
                         logic [SPEED_W-1:0] v, logic [IDX_W-1:0] idx);
        if (!tx_calm && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        time_us    <= t;
        speed      <= v;
        read_index <= idx;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic sample(logic [TIME_W-1:0] t, logic [SPEED_W-1:0] v);
        offer(FUNC_SAMPLE, t, v, IDX_W'($urandom));
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
        repeat (DUT_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_regs(t_reg_set s);
        for (int r = CFG_BAND_LOW; r <= CFG_REARM; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= s[r];
            do @(posedge clk); while (!cfg_ready);
            tracker.set_reg(CFG_IDX_W'(r), s[r]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic t_reg_set make_set(logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] hi,
                                          logic [SPEED_W-1:0] m1, logic [SPEED_W-1:0] m2,
                                          logic [SPEED_W-1:0] m3, logic [SPEED_W-1:0] re);
        t_reg_set s;
        s[CFG_BAND_LOW]  = lo;
        s[CFG_BAND_HIGH] = hi;
        s[CFG_MARK1]     = m1;
        s[CFG_MARK2]     = m2;
        s[CFG_MARK3]     = m3;
        s[CFG_REARM]     = re;
        return s;
    endfunction

    function automatic t_reg_set ordered_set();
        int unsigned lo, hi, m1, m2, m3;
        lo = $urandom_range(200);
        hi = lo + $urandom_range(200, 1);
        m1 = hi + $urandom_range(2000);
        m2 = m1 + $urandom_range(2000, 1);
        m3 = m2 + $urandom_range(2000, 1);
        return make_set(SPEED_W'(lo), SPEED_W'(hi), SPEED_W'(m1), SPEED_W'(m2),
                        SPEED_W'(m3), SPEED_W'($urandom_range(m3)));
    endfunction

    // Mostly sensor-like steps, some long enough to saturate the ms splits,
    // some repeated stamps, and rare jumps anywhere (out of order, wrapping).
    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            clock_us += TIME_W'($urandom_range(2_000_000, 1));
        else if (pick < 85)
            clock_us += TIME_W'($urandom_range(100_000_000, 2_000_000));
        else if (pick >= 95)
            clock_us = TIME_W'({$urandom, $urandom});
        return clock_us;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_in(int unsigned lo, int unsigned hi_excl);
        if (hi_excl > lo)
            return SPEED_W'($urandom_range(hi_excl - 1, lo));
        return SPEED_W'($urandom);
    endfunction

    function automatic logic [SPEED_W-1:0] at_least(int unsigned lo);
        if ($urandom_range(3) == 0)
            return SPEED_W'(lo);
        return SPEED_W'($urandom_range(65535, lo));
    endfunction

    function automatic logic [IDX_W-1:0] read_pick();
        if (tracker.runs_saved > 0 && $urandom_range(3) != 0)
            return IDX_W'($urandom_range(tracker.runs_saved - 1, 0));
        return IDX_W'($urandom);
    endfunction

    // Occasional reads, unused func codes and clears between samples.
    task automatic side_traffic(bit allow_clear);
        int unsigned pick;
        pick = $urandom_range(999);
        if (pick < 90)
            offer(FUNC_READ, next_stamp(), SPEED_W'($urandom), read_pick());
        else if (pick < 100)
            offer(FUNC_UNUSED, TIME_W'({$urandom, $urandom}), SPEED_W'($urandom),
                  IDX_W'($urandom));
        else if (pick < 104 && allow_clear)
            offer(FUNC_CLEAR, TIME_W'({$urandom, $urandom}), SPEED_W'($urandom),
                  IDX_W'($urandom));
    endtask

    task automatic step(logic [SPEED_W-1:0] v, bit lean);
        side_traffic(!lean);
        sample(next_stamp(), v);
    endtask

    // One full run shaped by the current thresholds: start band, three marks,
    // drop below the third mark, rearm. Lean runs skip the filler samples.
    task automatic run_once(bit lean);
        int unsigned lo, hi, m1, m2, m3, re;
        lo = tracker.thr[CFG_BAND_LOW];
        hi = tracker.thr[CFG_BAND_HIGH];
        m1 = tracker.thr[CFG_MARK1];
        m2 = tracker.thr[CFG_MARK2];
        m3 = tracker.thr[CFG_MARK3];
        re = tracker.thr[CFG_REARM];
        repeat (lean ? 0 : $urandom_range(2)) step(speed_in(0, m1), lean);
        step(speed_in(lo, hi), lean);
        repeat (lean ? 0 : $urandom_range(2)) step(speed_in(hi, m1), lean);
        step(at_least(m1), lean);
        repeat (lean ? 0 : $urandom_range(2)) step(speed_in(m1, m2), lean);
        step(at_least(m2), lean);
        repeat (lean ? 0 : $urandom_range(2)) step(speed_in(m2, m3), lean);
        step(at_least(m3), lean);
        repeat (lean ? 0 : $urandom_range(2)) step(at_least(m3), lean);
        step(speed_in(0, m3), lean);
        repeat (lean ? 0 : $urandom_range(2)) step(speed_in(re, 65536), lean);
        step(speed_in(0, re), lean);
    endtask

    // Mostly well-formed runs; the rest stray samples with any speed.
    task automatic exercise(int unsigned quota);
        int unsigned stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15)
                step(SPEED_W'($urandom), 1'b0);
            else
                run_once(1'b0);
        end
    endtask

    task automatic phase_with(t_reg_set s, int unsigned quota);
        settle();
        write_regs(s);
        exercise(quota);
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_SAMPLE;
        time_us    = '0;
        speed      = '0;
        read_index = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BAND_LOW;
        cfg_data   = '0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        clock_us   = TIME_W'({$urandom, $urandom});
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset thresholds.
        offer(FUNC_READ, TIME_TOP, 16'hFFFF, 5'h1F);             // empty history
        offer(FUNC_UNUSED, TIME_TOP, 16'hFFFF, 5'h1F);           // ignored code
        sample('0, '0);
        sample(TIME_TOP - 999, RST_BAND_LOW);                    // band low is inclusive
        sample(TIME_TOP - 499, RST_BAND_HIGH - 1);               // start time moves
        sample(TIME_TOP - 100, RST_BAND_HIGH);                   // band high is exclusive
        sample(TIME_TOP, RST_MARK1 - 1);
        sample(48'd300, RST_MARK1);                              // timer wrapped since start
        sample(48'd1_300, RST_MARK2 - 1);
        sample(48'd70_001_300, RST_MARK2);                       // split beyond 65.5 s
        sample(48'd70_002_000, RST_MARK3 - 1);
        sample(48'd70_500_000, RST_MARK3);
        sample(48'd70_600_000, 16'hFFFF);
        sample(48'd70_700_000, RST_MARK3 - 1);                   // run saved
        offer(FUNC_READ, '0, '0, '0);
        sample(48'd71_000_000, RST_REARM);                       // stays saved
        sample(48'd71_100_000, RST_REARM - 1);                   // rearmed
        sample(48'd72_000_000, 16'hFFFF);                        // first mark with no start
        offer(FUNC_CLEAR, TIME_TOP, 16'hFFFF, 5'h1F);
        offer(FUNC_READ, '0, '0, '0);                            // gone after clear
        // marks stamped out of order: every delta but start to first wraps
        sample(48'd5_000_000, RST_BAND_LOW);
        sample(48'd9_000_000, RST_MARK1);
        sample(48'd2_000_000, RST_MARK2);
        sample(48'd1_000_000, RST_MARK3);
        sample(48'd1_500_000, '0);

        // Back-to-back stretch with no idling on either side; enough short
        // runs to fill the history and run past it.
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (36) run_once(1'b1);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
        exercise(60);

        // Long receiver hold while the sender keeps pushing.
        tx_calm = 1'b1;
        hold_asks++;
        exercise(40);
        tx_calm = 1'b0;
        exercise(60);

        // Threshold sweeps: extremes, misordered bands and marks, random sane sets.
        phase_with(make_set(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 90);
        phase_with(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 50);
        phase_with(make_set(16'd0, 16'hFFFF, 16'd100, 16'd200, 16'd300, 16'hFFFF), 90);
        phase_with(make_set(16'd500, 16'd100, 16'd3000, 16'd2000, 16'd1000, 16'd50), 90);
        repeat (4) phase_with(ordered_set(), 60);
        phase_with(make_set(RST_BAND_LOW, RST_BAND_HIGH, RST_MARK1, RST_MARK2, RST_MARK3,
                            RST_REARM), 60);

        settle();
        if (tracker.failures == 0)
            $display("** acceleration_split_timer_core: PASSED **");
        else
            $display("** acceleration_split_timer_core: FAILED **");
        $finish;
    end

endmodule
